// ===== rtl/bwa_pkg.sv =====
// Shared types and constants for the bitrate window adapter.
// No dependencies; imported by every module of the block but bwa_ram.
`timescale 1ns / 1ps
`default_nettype none

package bwa_pkg;

    // Field widths
    localparam int RATE_W = 20;
    localparam int TIME_W = 48;
    localparam int INTV_W = 16;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 1;

    // Default window length
    localparam int WINDOW_DEF = 10;

    // Reset values of the configuration registers
    localparam logic [RATE_W-1:0] MAX_RESET = RATE_W'(4000);
    localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(1000);

    // Rule constants: decrease when sample*10 <= current*9,
    // increase when mean*5 > current*6
    localparam int DEC_SAMPLE_MUL = 10;
    localparam int DEC_CUR_MUL = 9;
    localparam int INC_MEAN_MUL = 5;
    localparam int INC_CUR_MUL = 6;
    localparam int US_PER_MS = 1000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_INTV = 1'b1;

    // Change codes
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INC = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_SCAN,
        S_TRIM,
        S_DIV,
        S_INC,
        S_OUT
    } t_state;

    // Control from the sequencer to the window accumulator
    typedef struct packed {
        logic clr;
        logic add;
        logic fin;
    } t_acc_ctrl;

endpackage

`default_nettype wire

// ===== rtl/bwa_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bwa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bwa_acc.sv =====
// Window accumulator: sum, largest and smallest entry over a scan of the window,
// then the trimmed total. Depends on bwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwa_acc
    import bwa_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire t_acc_ctrl                           i_ctrl,
    input  wire logic [RATE_W-1:0]                   i_data,
    output      logic [RATE_W+$clog2(WINDOW)-1:0]    o_tot,
    output      logic                                o_tot_vld
);

    localparam int SW = RATE_W + $clog2(WINDOW);

    logic [SW-1:0]     r_sum;
    logic [RATE_W-1:0] r_hi;
    logic [RATE_W-1:0] r_lo;
    logic [SW-1:0]     r_tot;
    logic              r_tot_vld;

    // Clear before a scan, fold in each read word, then trim
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_sum <= '0;
            r_hi  <= '0;
            r_lo  <= '1;
        end else if (i_ctrl.add) begin
            r_sum <= r_sum + SW'(i_data);
            if (i_data > r_hi) begin
                r_hi <= i_data;
            end
            if (i_data < r_lo) begin
                r_lo <= i_data;
            end
        end
        if (i_ctrl.fin) begin
            r_tot <= r_sum - SW'(r_hi) - SW'(r_lo);
        end
    end

    // Flag the trimmed total for the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_vld <= 1'b0;
        end else begin
            r_tot_vld <= i_ctrl.fin;
        end
    end

    assign o_tot     = r_tot;
    assign o_tot_vld = r_tot_vld;

endmodule

`default_nettype wire

// ===== rtl/bwa_div.sv =====
// Two-stage divider of the trimmed total by WINDOW-2: reciprocal multiply,
// then one correction step. Depends on bwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwa_div
    import bwa_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [RATE_W+$clog2(WINDOW)-1:0] i_tot,
    output      logic [RATE_W-1:0]                o_mean,
    output      logic                             o_done
);

    localparam int SW = RATE_W + $clog2(WINDOW);
    localparam int DW = $clog2(WINDOW);
    localparam int PW = 2 * SW;
    localparam int DIVISOR = WINDOW - 2;
    // floor(2^SW / divisor): the estimate is the quotient or one below it
    localparam logic [SW-1:0] RECIP = SW'((64'd1 << SW) / DIVISOR);
    localparam logic [SW-1:0] DIV_V = SW'(DIVISOR);

    logic [PW-1:0]     r_prod;
    logic [SW-1:0]     r_tot;
    logic              r_v1;
    logic [RATE_W-1:0] r_mean;
    logic              r_done;

    logic [SW-1:0]    q0;
    logic [SW+DW-1:0] qd;
    logic [SW+DW-1:0] rem_w;
    logic [SW-1:0]    rem;
    logic [SW-1:0]    quo;

    // Correct the estimate by one where the remainder reaches the divisor
    always_comb begin
        q0    = r_prod[PW-1:SW];
        qd    = (SW+DW)'(q0) * (SW+DW)'(DIVISOR);
        rem_w = (SW+DW)'(r_tot) - qd;
        rem   = rem_w[SW-1:0];
        quo   = (rem >= DIV_V) ? q0 + SW'(1) : q0;
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PW'(i_tot) * PW'(RECIP);
            r_tot  <= i_tot;
        end
        if (r_v1) begin
            r_mean <= quo[RATE_W-1:0];
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
    end

    assign o_mean = r_mean;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/bitrate_window_adapter.sv =====
// Top level of the bitrate window adapter: sequencer, state registers, window RAM,
// accumulator and divider. Depends on bwa_pkg, bwa_ram, bwa_acc, bwa_div.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready   | i_sample_kbps, i_now_us
//  output   | o_out_valid / i_out_ready | o_bitrate_kbps, o_change_kind
//  config   | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// Without a window scan an item passes S_DEC and S_OUT on its way to the result;
// when the increase rule is evaluated it also passes S_SCAN, S_TRIM, S_DIV and
// S_INC; the scan reads the window RAM an entry a cycle via its single read port.
// One item is in work at a time; the next is taken once the result is loaded
// into the output register, even while that result still waits to be taken.
// Synchronous active-low reset: current rate to 4000, window empty.
`timescale 1ns / 1ps
`default_nettype none

module bitrate_window_adapter
    import bwa_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    input  wire logic [RATE_W-1:0]    i_sample_kbps,
    input  wire logic [TIME_W-1:0]    i_now_us,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    output      logic [RATE_W-1:0]    o_bitrate_kbps,
    output      logic [KIND_W-1:0]    o_change_kind,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [RATE_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = RATE_W + AW;
    localparam logic [CW-1:0] WIN_C = CW'(WINDOW);
    localparam logic [AW-1:0] LAST_A = AW'(WINDOW - 1);

    t_state r_state;
    t_state n_state;

    logic [RATE_W-1:0] r_max;
    logic [INTV_W-1:0] r_intv;
    logic [RATE_W-1:0] r_sample;
    logic [TIME_W-1:0] r_now;
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [RATE_W-1:0] r_cur;
    logic [TIME_W-1:0] r_last;
    logic [TIME_W:0]   r_deadline;
    logic [KIND_W-1:0] r_kind;
    logic [CW-1:0]     r_idx;
    logic              r_rd_vld;
    logic              r_out_valid;
    logic [RATE_W-1:0] r_out_rate;
    logic [KIND_W-1:0] r_out_kind;

    logic              accept;
    logic              dec_hit;
    logic              inc_try;
    logic              inc_hit;
    logic              out_load;
    logic [RATE_W-1:0] rd_data;
    logic [SW-1:0]     tot;
    logic              tot_vld;
    logic [RATE_W-1:0] mean;
    logic              div_done;
    t_acc_ctrl         acc_ctrl;

    assign accept = i_in_valid && o_in_ready;

    // Rule tests
    always_comb begin
        dec_hit = (24'(r_sample) * 24'(DEC_SAMPLE_MUL)) <= (24'(r_cur) * 24'(DEC_CUR_MUL));
        inc_try = (r_count == WIN_C) && (r_cur < r_max);
        inc_hit = ((23'(mean) * 23'(INC_MEAN_MUL)) > (23'(r_cur) * 23'(INC_CUR_MUL)))
                  && (r_sample >= mean)
                  && ({1'b0, r_now} > r_deadline);
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        out_load     = 1'b0;
        acc_ctrl.clr = 1'b0;
        acc_ctrl.add = r_rd_vld;
        acc_ctrl.fin = 1'b0;
        case (r_state)
            S_IDLE: begin
                // hold off input while in reset
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                acc_ctrl.clr = 1'b1;
                if (!dec_hit && inc_try) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                if (r_rd_vld && (r_idx == WIN_C)) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                acc_ctrl.fin = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_INC;
                end
            end
            S_INC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= MAX_RESET;
            r_intv <= INTV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_RATE: r_max <= i_cfg_data;
                CFG_INC_INTV: r_intv <= i_cfg_data[INTV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Rate state: window position, current rate and time of last change
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_cur   <= MAX_RESET;
            r_last  <= '0;
            r_kind  <= KIND_NONE;
        end else begin
            if (accept) begin
                r_head <= (r_head == LAST_A) ? '0 : r_head + AW'(1);
                if (r_count < WIN_C) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (r_state == S_DEC) begin
                if (dec_hit) begin
                    r_cur  <= r_sample;
                    r_last <= r_now;
                    r_kind <= KIND_DEC;
                end else begin
                    r_kind <= KIND_NONE;
                end
            end
            if ((r_state == S_INC) && inc_hit) begin
                r_cur  <= (mean > r_max) ? r_max : mean;
                r_last <= r_now;
                r_kind <= KIND_INC;
            end
        end
    end

    // Hold the item and the increase deadline
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample_kbps;
            r_now    <= i_now_us;
        end
        if (r_state == S_DEC) begin
            r_deadline <= {1'b0, r_last}
                          + (TIME_W+1)'(26'(r_intv) * 26'(US_PER_MS));
        end
    end

    // Scan address counter and read-data flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_state == S_DEC) begin
                r_idx <= '0;
            end else if ((r_state == S_SCAN) && (r_idx != WIN_C)) begin
                r_idx <= r_idx + CW'(1);
            end
            r_rd_vld <= (r_state == S_SCAN) && (r_idx != WIN_C);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rate <= r_cur;
            r_out_kind <= r_kind;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bitrate_kbps = r_out_rate;
    assign o_change_kind  = r_out_kind;

    // Window store: the sample is written at accept, scans come later
    bwa_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_head),
        .i_wdata (i_sample_kbps),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    bwa_acc #(
        .WINDOW (WINDOW)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (acc_ctrl),
        .i_data    (rd_data),
        .o_tot     (tot),
        .o_tot_vld (tot_vld)
    );

    bwa_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tot_vld),
        .i_tot   (tot),
        .o_mean  (mean),
        .o_done  (div_done)
    );

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= WIN_C)
        else $error("window fill count beyond window length");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result loaded outside the output state");

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider result outside the wait state");

    a_inc_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INC) && inc_hit |=> r_cur <= r_max)
        else $error("increase went above the cap");

    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_count == WIN_C)
        else $error("scan started on a window that is not full");

endmodule

`default_nettype wire
